@@ design/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants of the pulse period rescaler
// Register map, reset values, configuration and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int DEBOUNCE_W = 20;
    localparam int TIMEOUT_W  = 32;
    localparam int RATIO_W    = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // threshold is (interval * ratio) >> HALF_SHIFT: ratio is Q16, plus halving
    localparam int HALF_SHIFT = 17;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(2500);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(1000000);
    localparam logic [RATIO_W-1:0]    RATIO_RST    = RATIO_W'(72018);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_TIMEOUT  = 2'd1,
        REG_RATIO    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_us;
        logic [TIMEOUT_W-1:0]  timeout_us;
        logic [RATIO_W-1:0]    scale_ratio;
    } t_cfg;

    typedef struct packed {
        logic               wr;
        logic [RATIO_W-1:0] value;
    } t_ratio_upd;

    // packed so that pulse_level sits in the lowest bit
    typedef struct packed {
        logic active;
        logic toggled;
        logic pulse_level;
    } t_result;

endpackage

`default_nettype wire

@@ design/ppr_core.sv @@
// ----------------------------------------------------------------------------
// ppr_core: edge capture and toggle decision for one tick
// Keeps tick-relative times as running counters and the threshold products
// as running sums, so one tick needs only adds and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_core #(
    parameter int TIME_BITS = ppr_pkg::TIME_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire                  i_sensor_level,
    input  ppr_pkg::t_cfg        i_cfg,
    input  ppr_pkg::t_ratio_upd  i_ratio_upd,
    output ppr_pkg::t_result     o_result
);
    import ppr_pkg::*;

    localparam int PROD_W = TIME_BITS + RATIO_W;
    localparam int CMP_W  = TIME_BITS + TIMEOUT_W;

    logic                 r_last_level;
    logic [TIME_BITS-1:0] r_since_edge;
    logic [TIME_BITS-1:0] r_since_toggle;
    logic [TIME_BITS-1:0] r_interval;
    logic [PROD_W-1:0]    r_edge_prod;   // r_since_edge * ratio
    logic [PROD_W-1:0]    r_thr_prod;    // r_interval * ratio
    logic                 r_out_level;

    logic              capture;
    logic              active;
    logic              toggle;
    logic              tog_keep;
    logic              tog_cap;
    logic [PROD_W-1:0] ratio_ext;
    logic [PROD_W-1:0] st_ext;
    logic [PROD_W-1:0] n_edge_prod;

    always_comb begin
        ratio_ext = PROD_W'(i_cfg.scale_ratio);
        st_ext    = PROD_W'(r_since_toggle);
        capture   = r_last_level && !i_sensor_level &&
                    (CMP_W'(r_since_edge) > CMP_W'(i_cfg.debounce_us));
        // after a capture the time since the edge is zero
        active    = capture ? (i_cfg.timeout_us != '0)
                            : (CMP_W'(r_since_edge) < CMP_W'(i_cfg.timeout_us));
        tog_keep  = st_ext > (r_thr_prod >> HALF_SHIFT);
        tog_cap   = st_ext > (r_edge_prod >> HALF_SHIFT);
        toggle    = active && (capture ? tog_cap : tog_keep);
        if (capture) begin
            n_edge_prod = ratio_ext;
        end else if (&r_since_edge) begin
            n_edge_prod = '0;
        end else begin
            n_edge_prod = r_edge_prod + ratio_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b1;
            r_since_edge   <= '0;
            r_since_toggle <= '0;
            r_interval     <= '0;
            r_edge_prod    <= '0;
            r_thr_prod     <= '0;
            r_out_level    <= 1'b0;
        end else if (i_step) begin
            r_last_level   <= i_sensor_level;
            r_since_edge   <= capture ? TIME_BITS'(1) : r_since_edge + TIME_BITS'(1);
            r_since_toggle <= toggle ? TIME_BITS'(1) : r_since_toggle + TIME_BITS'(1);
            r_edge_prod    <= n_edge_prod;
            if (capture) begin
                r_interval <= r_since_edge;
                r_thr_prod <= r_edge_prod;
            end
            if (toggle) begin
                r_out_level <= ~r_out_level;
            end
        end else if (i_ratio_upd.wr) begin
            // new ratio: rebuild both products from the held times
            r_edge_prod <= PROD_W'(r_since_edge) * PROD_W'(i_ratio_upd.value);
            r_thr_prod  <= PROD_W'(r_interval) * PROD_W'(i_ratio_upd.value);
        end
    end

    assign o_result.pulse_level = r_out_level ^ toggle;
    assign o_result.toggled     = toggle;
    assign o_result.active      = active;

endmodule

`default_nettype wire

@@ design/pulse_period_rescaler_top.sv @@
// ----------------------------------------------------------------------------
// pulse_period_rescaler_top: speedometer pulse frequency rescaler
// Regenerates a drive level whose frequency is the sensor pulse frequency
// scaled by a programmable ratio.
// ----------------------------------------------------------------------------
// Usage:
//   Send one transfer on the s_axis channel per microsecond tick, carrying
//   the sensor level in tdata bit 0. Each transfer yields exactly one
//   transfer on m_axis with the drive level, a toggle flag and an active flag.
//   Each result is registered before it reaches m_axis; a new tick is taken
//   every cycle while s_axis_tready is high, as one tick needs only the
//   add/compare update of the interval counters and running threshold products.
//   An output register plus one skid entry let the input keep flowing while
//   a result waits; s_axis_tready drops while the skid entry is full. A
//   stalled receiver that meets a waiting result and a new transfer fills
//   it, and tready rises again in the cycle after the receiver resumes.
//   Registers sit on an APB port: debounce_us at 0x0, timeout_us at 0x4,
//   scale_ratio at 0x8; write them only while no tick is in flight.
//   Reset clears the timers, sets the sensor history high, the drive level
//   low and the registers to 2500 us, 1000000 us and 72018 (Q16).
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_period_rescaler_top #(
    parameter int TIME_BITS = ppr_pkg::TIME_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // s_axis: bit 0 sensor_level, bits 7:1 zero
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [7:0]                       s_axis_tdata,
    // m_axis: bit 0 pulse_level, bit 1 toggled, bit 2 active, bits 7:3 zero
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [7:0]                       m_axis_tdata,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [ppr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire  [ppr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ppr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import ppr_pkg::*;

    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic [RATIO_W-1:0]    r_ratio;

    t_reg_idx   reg_idx;
    logic       cfg_wr;
    t_cfg       cfg;
    t_ratio_upd ratio_upd;

    t_result r_out_data;
    logic    r_out_vld;
    t_result r_skid_data;
    logic    r_skid_vld;

    t_result step_res;
    logic    step;
    logic    out_fire;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_timeout  <= TIMEOUT_RST;
            r_ratio    <= RATIO_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEBOUNCE: r_debounce <= pwdata[DEBOUNCE_W-1:0];
                REG_TIMEOUT:  r_timeout  <= pwdata[TIMEOUT_W-1:0];
                REG_RATIO:    r_ratio    <= pwdata[RATIO_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE: prdata = CFG_DATA_W'(r_debounce);
            REG_TIMEOUT:  prdata = CFG_DATA_W'(r_timeout);
            REG_RATIO:    prdata = CFG_DATA_W'(r_ratio);
            default:      prdata = '0;
        endcase
    end

    assign cfg.debounce_us = r_debounce;
    assign cfg.timeout_us  = r_timeout;
    assign cfg.scale_ratio = r_ratio;
    assign ratio_upd.wr    = cfg_wr && (reg_idx == REG_RATIO);
    assign ratio_upd.value = pwdata[RATIO_W-1:0];

    // tick processing
    assign s_axis_tready = !r_skid_vld;
    assign step          = s_axis_tvalid && s_axis_tready;

    ppr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_sensor_level (s_axis_tdata[0]),
        .i_cfg          (cfg),
        .i_ratio_upd    (ratio_upd),
        .o_result       (step_res)
    );

    // output register with one skid entry
    assign out_fire = r_out_vld && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_fire || !r_out_vld) begin
            r_out_vld  <= r_skid_vld || step;
            r_skid_vld <= 1'b0;
        end else if (step) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_vld) begin
            r_out_data <= r_skid_vld ? r_skid_data : step_res;
        end else if (step) begin
            r_skid_data <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out_data};

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds data while output register is empty");

    a_toggle_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
        else $error("toggle reported on an inactive tick");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output channel not idle after reset");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("accepted tick produced no pending result");
`endif

endmodule

`default_nettype wire
